// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/mbrf_pkg.sv =====
// Shared constants and CRC-16/MODBUS helper for the request framer.
`default_nettype none

package mbrf_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned CrcSpan  = 6;
  localparam int unsigned ByteIdxW = $clog2(FrameLen);
  localparam logic [ByteIdxW-1:0] LastIdx = ByteIdxW'(FrameLen - 1);

  localparam logic       CmdRead  = 1'b0;
  localparam logic       CmdWrite = 1'b1;

  localparam logic [7:0] FcReadHolding = 8'h03;
  localparam logic [7:0] FcWriteSingle = 8'h06;

  localparam logic [7:0]  SlaveAddrReset = 8'h01;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPoly        = 16'hA001;

  typedef logic [FrameLen-1:0][7:0] frame_t;

  // One byte through the reflected CRC, LSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/modbus_rtu_request_framer.sv =====
// Modbus RTU request framer: one request in, eight frame bytes out.
// An accepted request is registered in the input register, then loaded into the frame register.
// Request rate is set by the one-byte output port, which sends each frame a byte at a time.
// A new request is taken into the input register while a frame is still sent.
// Reset clears all valid flags and sets the slave address to 1.
`default_nettype none

module modbus_rtu_request_framer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [15:0] reg_address_i,
  input  wire logic [15:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       frame_byte_o,
  output logic             last_o
);
  import mbrf_pkg::*;

  logic [7:0]          slave_addr_r_q;
  logic                a_valid_q, a_valid_d;
  logic                a_cmd_q;
  logic [15:0]         a_addr_q, a_val_q;
  logic                b_valid_q, b_valid_d;
  logic [ByteIdxW-1:0] b_idx_q, b_idx_d;
  frame_t              b_frame_q, frame_d;
  logic [15:0]         crc;
  logic                in_acc, out_acc, b_done, b_load;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = b_valid_q && out_ready_i;
  assign b_done  = out_acc && (b_idx_q == LastIdx);
  assign b_load  = a_valid_q && (!b_valid_q || b_done);

  assign in_ready_o   = !a_valid_q || b_load;
  assign out_valid_o  = b_valid_q;
  assign frame_byte_o = b_frame_q[b_idx_q];
  assign last_o       = (b_idx_q == LastIdx);

  always_comb begin
    frame_d    = '0;
    frame_d[0] = slave_addr_r_q;
    frame_d[1] = (a_cmd_q == CmdWrite) ? FcWriteSingle : FcReadHolding;
    frame_d[2] = a_addr_q[15:8];
    frame_d[3] = a_addr_q[7:0];
    frame_d[4] = a_val_q[15:8];
    frame_d[5] = a_val_q[7:0];
    crc = CrcInit;
    for (int i = 0; i < CrcSpan; i++) begin
      crc = crc16_byte(crc, frame_d[i]);
    end
    frame_d[6] = crc[7:0];
    frame_d[7] = crc[15:8];
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_acc) begin
      a_valid_d = 1'b1;
    end else if (b_load) begin
      a_valid_d = 1'b0;
    end
    b_valid_d = b_valid_q;
    b_idx_d   = b_idx_q;
    if (b_load) begin
      b_valid_d = 1'b1;
      b_idx_d   = '0;
    end else if (b_done) begin
      b_valid_d = 1'b0;
      b_idx_d   = '0;
    end else if (out_acc) begin
      b_idx_d = b_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_r_q <= SlaveAddrReset;
      a_valid_q      <= 1'b0;
      b_valid_q      <= 1'b0;
      b_idx_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        slave_addr_r_q <= cfg_wdata_i;
      end
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      b_idx_q   <= b_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_cmd_q  <= cmd_i;
      a_addr_q <= reg_address_i;
      a_val_q  <= value_i;
    end
    if (b_load) begin
      b_frame_q <= frame_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/mbrf_checker.sv =====
// Port-level checker for the request framer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mbrf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  frame_byte_o,
  input wire logic        last_o
);
  import mbrf_pkg::*;

  logic [ByteIdxW-1:0] beat_cnt_q;

  // position of the current beat within its frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      beat_cnt_q <= beat_cnt_q + 1'b1;
    end
  end

  `ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(frame_byte_o))
  `ASSERT_NOW(a_last_pos, out_valid_o, last_o == (beat_cnt_q == LastIdx))
  `ASSERT_NOW(a_func_code, out_valid_o && (beat_cnt_q == ByteIdxW'(1)), (frame_byte_o == FcReadHolding) || (frame_byte_o == FcWriteSingle))
  `ASSERT_NXT(a_frame_cont, out_valid_o && out_ready_i && !last_o, out_valid_o)

endmodule

bind modbus_rtu_request_framer mbrf_checker u_mbrf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .frame_byte_o (frame_byte_o),
  .last_o       (last_o)
);

`default_nettype wire

// ===== verif/mbrf_frame_checker.sv =====
`timescale 1ns / 100ps
// Frame checker for the Modbus RTU request framer: predicts each frame, compares output beats.
module mbrf_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [15:0] reg_address_i,
  input  logic [15:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import mbrf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } frame_beat_t;

  logic [7:0]  slave_addr;
  frame_beat_t tx_beats_q[$];

  function automatic void queue_request_frame(logic cmd, logic [15:0] addr, logic [15:0] val);
    logic [7:0]  frame_bytes [FrameLen];
    logic [15:0] crc;
    frame_bytes[0] = slave_addr;
    frame_bytes[1] = (cmd == CmdWrite) ? FcWriteSingle : FcReadHolding;
    frame_bytes[2] = addr[15:8];
    frame_bytes[3] = addr[7:0];
    frame_bytes[4] = val[15:8];
    frame_bytes[5] = val[7:0];
    crc = CrcInit;
    for (int n = 0; n < CrcSpan; n++) begin
      crc = crc ^ {8'h00, frame_bytes[n]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
      end
    end
    // CRC goes out low byte first
    frame_bytes[6] = crc[7:0];
    frame_bytes[7] = crc[15:8];
    for (int k = 0; k < FrameLen; k++) begin
      tx_beats_q.push_back('{data: frame_bytes[k], is_last: (k == FrameLen - 1)});
    end
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count_o < 40) begin
      $display("%0t mismatch: %s", $time, what);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_beat_t want;
    if (!rst_ni) begin
      slave_addr = SlaveAddrReset;
      tx_beats_q.delete();
    end else begin
      if (cfg_we_i) begin
        slave_addr = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (tx_beats_q.size() == 0) begin
          report_mismatch($sformatf("beat with no frame pending: byte %02h last %b",
                                    frame_byte_i, last_i));
        end else begin
          want = tx_beats_q.pop_front();
          if (frame_byte_i !== want.data) begin
            report_mismatch($sformatf("frame_byte %02h, want %02h", frame_byte_i, want.data));
          end
          if (last_i !== want.is_last) begin
            report_mismatch($sformatf("last %b, want %b (byte %02h)",
                                      last_i, want.is_last, want.data));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        queue_request_frame(cmd_i, reg_address_i, value_i);
      end
    end
    pending_o = tx_beats_q.size();
  end

endmodule

// ===== verif/tb_modbus_rtu_request_framer.sv =====
`timescale 1ns / 100ps
// Testbench top for the Modbus RTU request framer: stimulus, handshake idling and verdict.
module tb_modbus_rtu_request_framer;
  import mbrf_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned RandomPhases  = 5;
  localparam int unsigned ItemsPerPhase = 100;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [7:0]  cfg_wdata   = 8'h00;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic        cmd         = CmdRead;
  logic [15:0] reg_address = 16'h0000;
  logic [15:0] value       = 16'h0000;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_beat;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycles     = 0;
  int unsigned gap_pct    = 30;
  int unsigned stall_pct  = 30;
  int unsigned stall_left = 0;
  bit          calm       = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  modbus_rtu_request_framer i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .reg_address_i (reg_address),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .frame_byte_o  (frame_byte),
    .last_o        (last_beat)
  );

  mbrf_frame_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .cmd_i         (cmd),
    .reg_address_i (reg_address),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .frame_byte_i  (frame_byte),
    .last_i        (last_beat),
    .pending_o     (pending),
    .fail_count_o  (mismatches)
  );

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_modbus_rtu_request_framer NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // one request beat; entered and left at a falling edge
  task automatic send_request(logic c, logic [15:0] a, logic [15:0] v);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    cmd         = c;
    reg_address = a;
    value       = v;
    in_valid    = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  // register writes only with no frame in flight
  task automatic set_slave_address(logic [7:0] addr);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = addr;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic        c;
    logic [15:0] a;
    logic [15:0] v;
    logic [7:0]  slave;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset slave address, field extremes, count zero and above 125
    send_request(CmdRead,  16'h0000, 16'h0000);
    send_request(CmdRead,  16'hFFFF, 16'hFFFF);
    send_request(CmdWrite, 16'h0000, 16'h0000);
    send_request(CmdWrite, 16'hFFFF, 16'hFFFF);
    send_request(CmdRead,  16'h0001, 16'h007D);
    send_request(CmdRead,  16'h0001, 16'h007E);
    send_request(CmdWrite, 16'hA5A5, 16'h5A5A);
    send_request(CmdWrite, 16'h5A5A, 16'hA5A5);
    send_request(CmdRead,  16'h8000, 16'h0001);
    send_request(CmdWrite, 16'h0001, 16'h8000);

    set_slave_address(8'h00);
    send_request(CmdRead,  16'h1234, 16'h000A);
    send_request(CmdWrite, 16'hFFFF, 16'h0000);

    set_slave_address(8'hFF);
    send_request(CmdWrite, 16'h0000, 16'hFFFF);
    send_request(CmdRead,  16'h006B, 16'h0003);
    send_request(CmdWrite, 16'h0001, 16'h0003);

    for (int p = 0; p < RandomPhases; p++) begin
      calm      = (p == RandomPhases - 1);
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      case ($urandom_range(0, 3))
        0:       slave = 8'h00;
        1:       slave = 8'hFF;
        default: slave = 8'($urandom_range(0, 255));
      endcase
      if (calm) begin
        slave = SlaveAddrReset;
      end
      set_slave_address(slave);
      repeat (ItemsPerPhase) begin
        c = 1'($urandom_range(0, 1));
        a = random_word();
        if (c == CmdRead && $urandom_range(0, 2) != 0) begin
          v = 16'($urandom_range(1, 125));
        end else begin
          v = random_word();
        end
        send_request(c, a, v);
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_modbus_rtu_request_framer OK");
    end else begin
      $display("tb_modbus_rtu_request_framer NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mbrf_pkg.sv
src/modbus_rtu_request_framer.sv
src/mbrf_checker.sv
verif/mbrf_frame_checker.sv
verif/tb_modbus_rtu_request_framer.sv
